/* rtl/sdspi_pkg.sv */
// Package: constants, codes and tables for the SD card SPI-mode responder.
package sdspi_pkg;
  localparam int unsigned MaxBlockBytes = 512;
  localparam int unsigned ImageBytes    = 65536;
  localparam int unsigned AddrW         = $clog2(ImageBytes);
  localparam int unsigned BlkW          = $clog2(MaxBlockBytes + 1);
  localparam int unsigned SizeW         = 17;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 17;
  localparam int unsigned XAddrW        = 41;

  localparam logic [CfgIdxW-1:0] CfgCardPresent  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCardSize     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWriteProtect = 2'd2;

  localparam logic [7:0] CmdReset  = 8'h40;
  localparam logic [7:0] CmdInit   = 8'h41;
  localparam logic [7:0] CmdInitB  = 8'h77;
  localparam logic [7:0] CmdAcmd41 = 8'h69;
  localparam logic [7:0] CmdIfCond = 8'h48;
  localparam logic [7:0] CmdCid    = 8'h4a;
  localparam logic [7:0] CmdBlkLen = 8'h50;
  localparam logic [7:0] CmdRead   = 8'h51;
  localparam logic [7:0] CmdWrite  = 8'h58;
  localparam logic [7:0] CmdOcr    = 8'h7a;

  localparam logic [7:0] TokData   = 8'hfe;
  localparam logic [7:0] RespWrOk  = 8'h05;
  localparam logic [7:0] Fill      = 8'hff;

  function automatic logic [7:0] id_byte(input logic [4:0] i);
    case (i)
      5'd0: id_byte = 8'hff;   5'd1: id_byte = 8'hfe;   5'd2: id_byte = 8'h01;
      5'd3: id_byte = 8'h00;   5'd4: id_byte = 8'h00;   5'd5: id_byte = 8'h33;
      5'd6: id_byte = 8'h32;   5'd12: id_byte = 8'h19;  5'd13: id_byte = 8'h88;
      5'd14: id_byte = 8'h4f;  5'd15: id_byte = 8'h7a;  5'd16: id_byte = 8'h34;
      5'd18: id_byte = 8'h6a;  5'd19: id_byte = 8'hca;
      default: id_byte = 8'hff;
    endcase
  endfunction
endpackage

/* rtl/sdspi_byte_if.sv */
// Interface: one valid/ready byte channel.
interface sdspi_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/sd_card_spi_mode_responder.sv */
// Top level: SD card SPI-mode responder with an internal image store.
//
// One host byte per input item gives one card byte per result item. Each item first
// reads the image store (single-port synchronous RAM, registered read data), then
// updates state and writes back. The output register frees the input while a result
// waits. After reset a clearing pass writes zero over all 65536 store bytes, one per
// cycle, before the first item is taken; configuration writes are taken throughout.
module sd_card_spi_mode_responder
  import sdspi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  sdspi_byte_if.sink         mosi_i,
  sdspi_byte_if.source       miso_o
);
  typedef enum logic [3:0] {
    PhIdle, PhArgs, PhEnd, PhId, PhEcho, PhRtoken, PhRdata, PhWtoken, PhWdata, PhWbusy
  } phase_e;

  logic             present_q, wp_q;
  logic [SizeW-1:0] size_q;

  phase_e           phase_q;
  logic [7:0]       cmd_q;
  logic [7:0]       arg_q [7];
  logic [BlkW-1:0]  cnt_q;
  logic [7:0]       sout_q;
  logic [BlkW-1:0]  blen_q;
  logic             hc_q, wfault_q;
  logic [XAddrW-1:0] xaddr_q;

  logic             clr_q;
  logic [AddrW-1:0] clr_addr_q;
  logic             busy_q;
  logic [7:0]       b_q;
  logic             ovalid_q;

  logic [7:0] mem [ImageBytes];
  logic [7:0] rdata_q;

  // byte address for the current data beat
  logic [XAddrW:0] p;
  logic            p_in;
  assign p    = {1'b0, xaddr_q} + {{(XAddrW + 1 - BlkW){1'b0}}, cnt_q};
  assign p_in = p < (XAddrW + 1)'(ImageBytes);

  logic mem_we;
  logic [AddrW-1:0] mem_addr;
  logic [7:0] mem_wd;

  // busy stage waits while the previous result is still held
  logic adv;
  assign adv = busy_q && (!ovalid_q || miso_o.ready);

  assign mosi_i.ready = !clr_q && !busy_q;
  assign miso_o.valid = ovalid_q;
  assign miso_o.data  = sout_q;

  logic accept;
  assign accept = mosi_i.valid && mosi_i.ready;

  logic active;
  assign active = present_q && (size_q != '0);

  always_comb begin
    mem_we   = 1'b0;
    mem_wd   = b_q;
    mem_addr = p[AddrW-1:0];
    if (clr_q) begin
      mem_we   = 1'b1;
      mem_addr = clr_addr_q;
      mem_wd   = '0;
    end else if (adv && active && phase_q == PhWdata) begin
      mem_we = !wfault_q && p_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    rdata_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
      wp_q      <= 1'b0;
      size_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgCardPresent:  present_q <= cfg_data_i[0];
        CfgCardSize:     size_q    <= cfg_data_i[SizeW-1:0];
        CfgWriteProtect: wp_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (&clr_addr_q) clr_q <= 1'b0;
    end
  end

  logic [31:0] a32;
  logic [XAddrW-1:0] ea;
  logic [XAddrW:0] eend;
  logic [SizeW-1:0] rlim;
  assign a32  = {arg_q[0], arg_q[1], arg_q[2], arg_q[3]};
  assign ea   = hc_q ? {a32, 9'd0} : {9'd0, a32};
  assign eend = {1'b0, ea} + {{(XAddrW + 1 - BlkW){1'b0}}, blen_q};
  assign rlim = (size_q < SizeW'(ImageBytes)) ? size_q : SizeW'(ImageBytes);

  logic [BlkW:0] cnt_inc;
  assign cnt_inc = {1'b0, cnt_q} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      cmd_q    <= '0;
      for (int i = 0; i < 7; i++) arg_q[i] <= '0;
      cnt_q    <= '0;
      sout_q   <= Fill;
      blen_q   <= BlkW'(MaxBlockBytes);
      hc_q     <= 1'b0;
      wfault_q <= 1'b0;
      xaddr_q  <= '0;
      busy_q   <= 1'b0;
      b_q      <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
        b_q    <= mosi_i.data;
      end
      if (adv) begin
        busy_q   <= 1'b0;
        ovalid_q <= 1'b1;
        if (active) begin
          case (phase_q)
            PhIdle: if (b_q != Fill) begin
              cmd_q   <= b_q;
              cnt_q   <= '0;
              phase_q <= PhArgs;
            end
            PhArgs: begin
              arg_q[cnt_q[2:0]] <= b_q;
              if (cnt_q == BlkW'(6)) begin
                cnt_q <= '0;
                case (cmd_q)
                  CmdReset: begin
                    sout_q  <= 8'h01;
                    phase_q <= PhIdle;
                  end
                  CmdAcmd41: begin
                    if (arg_q[0][6]) hc_q <= 1'b1;
                    sout_q  <= 8'h00;
                    phase_q <= PhIdle;
                  end
                  CmdInit, CmdInitB: begin
                    sout_q  <= 8'h00;
                    phase_q <= PhIdle;
                  end
                  CmdIfCond: begin
                    sout_q  <= 8'h01;
                    phase_q <= PhEcho;
                  end
                  CmdCid: begin
                    sout_q  <= 8'h00;
                    phase_q <= PhId;
                  end
                  CmdBlkLen: begin
                    phase_q <= PhIdle;
                    if (a32 != '0 && a32 <= 32'(MaxBlockBytes)) begin
                      blen_q <= a32[BlkW-1:0];
                      sout_q <= 8'h00;
                    end else sout_q <= 8'h40;
                  end
                  CmdRead: begin
                    xaddr_q <= ea;
                    if (ea >= XAddrW'(size_q)) begin
                      sout_q  <= 8'h40;
                      phase_q <= PhIdle;
                    end else if (eend > (XAddrW + 1)'(rlim)) begin
                      sout_q  <= Fill;
                      phase_q <= PhIdle;
                    end else begin
                      sout_q  <= 8'h00;
                      phase_q <= PhRtoken;
                    end
                  end
                  CmdWrite: begin
                    xaddr_q <= ea;
                    if (wp_q) begin
                      sout_q  <= Fill;
                      phase_q <= PhIdle;
                    end else begin
                      wfault_q <= eend > (XAddrW + 1)'(ImageBytes);
                      sout_q   <= 8'h00;
                      phase_q  <= PhWtoken;
                    end
                  end
                  CmdOcr: begin
                    sout_q   <= 8'h00;
                    arg_q[0] <= 8'h40;
                    phase_q  <= PhEcho;
                  end
                  default: begin
                    sout_q  <= Fill;
                    phase_q <= PhIdle;
                  end
                endcase
              end else begin
                cnt_q <= cnt_inc[BlkW-1:0];
              end
            end
            PhEnd: begin
              sout_q  <= Fill;
              phase_q <= PhIdle;
            end
            PhEcho: begin
              if (cnt_q >= BlkW'(4)) begin
                sout_q  <= 8'h00;
                phase_q <= PhIdle;
              end else begin
                sout_q <= arg_q[cnt_q[2:0]];
                cnt_q  <= cnt_inc[BlkW-1:0];
              end
            end
            PhId: begin
              sout_q <= id_byte(cnt_q[4:0]);
              cnt_q  <= cnt_inc[BlkW-1:0];
              if (cnt_q == BlkW'(19)) phase_q <= PhEnd;
            end
            PhRtoken: begin
              sout_q  <= TokData;
              cnt_q   <= '0;
              phase_q <= PhRdata;
            end
            PhRdata: begin
              sout_q <= p_in ? rdata_q : Fill;
              cnt_q  <= cnt_inc[BlkW-1:0];
              if (cnt_inc >= {1'b0, blen_q}) phase_q <= PhEnd;
            end
            PhWtoken: if (b_q == TokData) begin
              cnt_q   <= '0;
              phase_q <= PhWdata;
            end
            PhWdata: begin
              if (cnt_inc >= {1'b0, blen_q}) begin
                cnt_q <= '0;
                if (wfault_q) begin
                  sout_q  <= Fill;
                  phase_q <= PhIdle;
                end else begin
                  sout_q  <= RespWrOk;
                  phase_q <= PhWbusy;
                end
              end else begin
                cnt_q <= cnt_inc[BlkW-1:0];
              end
            end
            PhWbusy: begin
              cnt_q <= cnt_inc[BlkW-1:0];
              if (cnt_q == BlkW'(15)) begin
                sout_q  <= Fill;
                phase_q <= PhIdle;
              end
            end
            default: phase_q <= PhIdle;
          endcase
        end
      end else if (miso_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !accept) else $error("item taken during clear");
  a_busy_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && !mosi_i.ready) else $error("busy not set");
  a_out_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> ovalid_q) else $error("result missing");
  a_blen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blen_q != '0 && blen_q <= BlkW'(MaxBlockBytes)) else $error("bad block length");
endmodule
